// ----- hdl/bals_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bals_pkg
// Shared widths, constants and types of the brace-aware list splitter.
// ============================================================================
package bals_pkg;

    localparam int MAX_STRING_LEN = 4096;
    localparam int MAX_DELIM_LEN  = 8;

    localparam int POS_W     = 13;
    localparam int ITEM_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int DELIM_W   = 64;
    localparam int DLEN_W    = 4;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

    // span status codes
    localparam logic [STATUS_W-1:0] ST_NORMAL   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET  = 64'd6581857;
    localparam logic [DLEN_W-1:0]  DELIM_LENGTH_RESET = 4'd3;

    typedef struct packed {
        logic [DELIM_W-1:0] delim_bytes;
        logic [DLEN_W-1:0]  eff_len;     // effective, 1 .. MAX_DELIM_LEN
    } bals_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]    span_start;
        logic [POS_W-1:0]    span_stop;
        logic [ITEM_W-1:0]   item_number;
        logic [STATUS_W-1:0] span_status;
        logic                final_item;
    } bals_result_t;

endpackage

// ----- hdl/bals_cfg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bals_cfg
// Configuration registers; delimiter length clamped to its usable range.
// ============================================================================
module bals_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bals_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bals_pkg::DELIM_W-1:0]    cfg_wdata,
    output bals_pkg::bals_cfg_t             cfg_out
);
    import bals_pkg::*;

    logic [DELIM_W-1:0] delim_bytes_reg;
    logic [DLEN_W-1:0]  delim_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_bytes_reg  <= DELIM_BYTES_RESET;
            delim_length_reg <= DELIM_LENGTH_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DELIM_BYTES:  delim_bytes_reg  <= cfg_wdata;
                REG_DELIM_LENGTH: delim_length_reg <= cfg_wdata[DLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_out.delim_bytes = delim_bytes_reg;
        if (delim_length_reg == '0) begin
            cfg_out.eff_len = DLEN_W'(1);
        end else if (delim_length_reg > DLEN_W'(MAX_DELIM_LEN)) begin
            cfg_out.eff_len = DLEN_W'(MAX_DELIM_LEN);
        end else begin
            cfg_out.eff_len = delim_length_reg;
        end
    end

endmodule

// ----- hdl/bals_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bals_core
// Per-string state and the combinational byte step: brace depth, word flag,
// delimiter match and span bookkeeping.
// ============================================================================
module bals_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_take,
    input  logic [7:0]                 char_byte,
    input  logic                       end_of_string,
    input  bals_pkg::bals_cfg_t        cfg,
    output logic                       res_push,
    output bals_pkg::bals_result_t     res
);
    import bals_pkg::*;

    logic signed [7:0]   depth_reg, depth_next;
    logic [DLEN_W-1:0]   match_reg, match_next;
    logic                in_word_reg, in_word_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [ITEM_W-1:0]   items_reg, items_next;
    logic                too_long_reg, too_long_next;

    logic                tl;
    logic [7:0]          lc;
    logic [7:0]          dbyte;
    logic                plain;
    logic [POS_W-1:0]    len_plus1;
    logic [POS_W-1:0]    split_stop;
    logic [POS_W-1:0]    fin_stop;

    function automatic logic [STATUS_W-1:0] status_of(input logic [POS_W-1:0] start,
                                                      input logic [POS_W-1:0] stop);
        if (stop > start) begin
            return ST_NORMAL;
        end else if (stop < start) begin
            return ST_EMPTY;
        end
        return ST_ZERO_LEN;
    endfunction

    always_comb begin
        depth_next    = depth_reg;
        match_next    = match_reg;
        in_word_next  = in_word_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        items_next    = items_reg;
        too_long_next = too_long_reg;
        res_push      = 1'b0;
        res           = '0;
        plain         = 1'b0;

        tl  = too_long_reg || (pos_reg >= POS_W'(MAX_STRING_LEN));
        lc  = (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_Z) ?
              char_byte + CASE_OFFSET : char_byte;
        // only used while match_reg < eff_len <= 8
        dbyte = cfg.delim_bytes[{match_reg[2:0], 3'b000} +: 8];
        len_plus1  = POS_W'(cfg.eff_len) + POS_W'(1);
        split_stop = (pos_reg >= len_plus1) ? pos_reg - len_plus1 : '0;
        fin_stop   = tl ? POS_W'(MAX_STRING_LEN) : pos_reg + POS_W'(1);

        if (in_take) begin
            too_long_next = tl;
            if (!tl) begin
                if (match_reg >= cfg.eff_len) begin
                    if (char_byte == CHAR_SPACE && !end_of_string) begin
                        res_push        = 1'b1;
                        res.span_start  = start_reg;
                        res.span_stop   = split_stop;
                        res.item_number = items_reg;
                        res.span_status = status_of(start_reg, split_stop);
                        res.final_item  = 1'b0;
                        start_next      = pos_reg + POS_W'(1);
                        match_next      = '0;
                    end else begin
                        plain = 1'b1;
                    end
                end else if (depth_reg == 8'sd0 && !in_word_reg && lc == dbyte) begin
                    match_next = match_reg + DLEN_W'(1);
                end else begin
                    plain = 1'b1;
                end

                if (plain) begin
                    if (char_byte == CHAR_LBRACE && depth_reg != 8'sd127) begin
                        depth_next = depth_reg + 8'sd1;
                    end else if (char_byte == CHAR_RBRACE && depth_reg != -8'sd128) begin
                        depth_next = depth_reg - 8'sd1;
                    end
                    in_word_next = (char_byte != CHAR_SPACE);
                    match_next   = '0;
                end
                pos_next = pos_reg + POS_W'(1);
            end

            if (res_push && items_reg != {ITEM_W{1'b1}}) begin
                items_next = items_reg + ITEM_W'(1);
            end

            // a split never lands on the last byte, so one result at most
            if (end_of_string) begin
                res_push        = 1'b1;
                res.span_start  = start_reg;
                res.span_stop   = fin_stop;
                res.item_number = items_reg;
                res.span_status = tl ? ST_TOO_LONG : status_of(start_reg, fin_stop);
                res.final_item  = 1'b1;
                depth_next      = 8'sd0;
                match_next      = '0;
                in_word_next    = 1'b1;
                pos_next        = '0;
                start_next      = '0;
                items_next      = '0;
                too_long_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= 8'sd0;
            match_reg    <= '0;
            in_word_reg  <= 1'b1;
            pos_reg      <= '0;
            start_reg    <= '0;
            items_reg    <= '0;
            too_long_reg <= 1'b0;
        end else begin
            depth_reg    <= depth_next;
            match_reg    <= match_next;
            in_word_reg  <= in_word_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            items_reg    <= items_next;
            too_long_reg <= too_long_next;
        end
    end

endmodule

// ----- hdl/bals_out_buf.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bals_out_buf
// Result register with a skid stage, so input keeps flowing while a result
// waits on the downstream side.
// ============================================================================
module bals_out_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  bals_pkg::bals_result_t     push_data,
    output logic                       room,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bals_pkg::bals_result_t     out_data
);
    import bals_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    bals_result_t out_data_reg;
    bals_result_t skid_data_reg;
    logic         pop;

    assign pop       = out_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // no push can arrive while the skid stage is full
            if (pop) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- hdl/brace_aware_list_splitter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// brace_aware_list_splitter
// Splits a whitespace-collapsed string, one byte per item, into delimiter-
// separated spans, ignoring delimiters inside braces or inside words.
//
//   channel  direction  payload
//   s_       in         char_byte, end_of_string
//   m_       out        span_start, span_stop, item_number, span_status,
//                       final_item
//   cfg_     in         cfg_index (0 delim_bytes, 1 delim_length), cfg_wdata
//
// One byte accepted per cycle while s_ready is high; the byte step is
// combinational, so its result (at most one) is registered at the accepting
// edge, in the result register if free or being read, else in the skid stage.
// A skid stage holds one further result, so s_ready only drops when two
// results are waiting. Reset clears string state; config resets to "and".
// cfg_ready is always high.
// ============================================================================
module brace_aware_list_splitter (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_char_byte,
    input  logic                            s_end_of_string,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bals_pkg::POS_W-1:0]      m_span_start,
    output logic [bals_pkg::POS_W-1:0]      m_span_stop,
    output logic [bals_pkg::ITEM_W-1:0]     m_item_number,
    output logic [bals_pkg::STATUS_W-1:0]   m_span_status,
    output logic                            m_final_item,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bals_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bals_pkg::DELIM_W-1:0]    cfg_wdata
);
    import bals_pkg::*;

    bals_cfg_t    cfg;
    bals_result_t res;
    bals_result_t out_res;
    logic         res_push;
    logic         room;
    logic         take;

    assign s_ready = room;
    assign take    = s_valid && room;

    bals_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_out   (cfg)
    );

    bals_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_take       (take),
        .char_byte     (s_char_byte),
        .end_of_string (s_end_of_string),
        .cfg           (cfg),
        .res_push      (res_push),
        .res           (res)
    );

    bals_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_span_start  = out_res.span_start;
    assign m_span_stop   = out_res.span_stop;
    assign m_item_number = out_res.item_number;
    assign m_span_status = out_res.span_status;
    assign m_final_item  = out_res.final_item;

endmodule
